// ===== src/tga_pkg.sv =====
// ----------------------------------------------------------------------------
// tga_pkg: shared types and constants of the targa pixel stream decoder
// Decode phases, register indexes, the configuration view and the result beat.
// ----------------------------------------------------------------------------
package tga_pkg;

  // Decoder phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RAW    = 2'd1,
    PH_RUN    = 2'd2,
    PH_PLAIN  = 2'd3
  } decode_phase_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH     = 2'd0,
    CFG_IMAGE_HEIGHT    = 2'd1,
    CFG_BYTES_PER_PIXEL = 2'd2,
    CFG_RLE_MODE        = 2'd3
  } cfg_index_e;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PixCountW = 32;

  // Configuration as seen by the decoder
  typedef struct packed {
    logic [PixCountW-1:0] area;   // width * height
    logic                 is3;    // 3-byte pixels
    logic                 rle;    // run-length mode
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] rep;
    logic       last;
  } result_t;

endpackage

// ===== src/tga_pixel_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder: targa pixel data decoder, one byte per beat
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------
//   in      | input     | in_valid_i/in_stall_o | data_byte_i, start_image_i
//   out     | output    | out_valid_o/out_stall_i| pixel_byte0..3_o, repeat_count_o,
//           |           |                       | image_end_o
//   cfg     | input     | cfg_we_i              | cfg_index_i, cfg_wdata_i
//
// One byte is taken every cycle while in_stall_o is low; its state update is
// combinational; a finished pixel shows on the output from a buffer register.
// Results pass through a two-entry buffer; input stalls while both entries
// are occupied, which only builds up under a stalled consumer.
// Reset clears the decode state to "no image"; the first byte with
// start_image_i set begins decoding. Width * height is formed on the cfg write.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [tga_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         start_image_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   pixel_byte0_o,
  output logic [7:0]                   pixel_byte1_o,
  output logic [7:0]                   pixel_byte2_o,
  output logic [7:0]                   pixel_byte3_o,
  output logic [7:0]                   repeat_count_o,
  output logic                         image_end_o
);
  import tga_pkg::*;

  logic [CfgDataW-1:0]  width_q, width_d;
  logic [CfgDataW-1:0]  height_q, height_d;
  logic [2:0]           bpp_q, bpp_d;
  logic                 rle_q, rle_d;
  logic [PixCountW-1:0] area_q, area_d;

  cfg_t    cfg;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    full;

  // Register writes; keep the pixel count in step with the size
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    bpp_d    = bpp_q;
    rle_d    = rle_q;
    area_d   = area_q;
    if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_IMAGE_WIDTH: begin
          width_d = cfg_wdata_i;
          area_d  = PixCountW'(cfg_wdata_i) * PixCountW'(height_q);
        end
        CFG_IMAGE_HEIGHT: begin
          height_d = cfg_wdata_i;
          area_d   = PixCountW'(width_q) * PixCountW'(cfg_wdata_i);
        end
        CFG_BYTES_PER_PIXEL: bpp_d = cfg_wdata_i[2:0];
        CFG_RLE_MODE:        rle_d = cfg_wdata_i[0];
        default:             width_d = width_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgDataW'(1);
      height_q <= CfgDataW'(1);
      bpp_q    <= 3'd4;
      rle_q    <= 1'b1;
      area_q   <= PixCountW'(1);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      bpp_q    <= bpp_d;
      rle_q    <= rle_d;
      area_q   <= area_d;
    end
  end

  assign cfg.area = area_q;
  assign cfg.is3  = (bpp_q == 3'd3);
  assign cfg.rle  = rle_q;

  // Take a byte unless the result buffer is full
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  tga_dec_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .start_image_i (start_image_i),
    .cfg_i         (cfg),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  tga_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_res)
  );

  assign pixel_byte0_o  = out_res.byte0;
  assign pixel_byte1_o  = out_res.byte1;
  assign pixel_byte2_o  = out_res.byte2;
  assign pixel_byte3_o  = out_res.byte3;
  assign repeat_count_o = out_res.rep;
  assign image_end_o    = out_res.last;

endmodule

// ===== src/tga_dec_core.sv =====
// ----------------------------------------------------------------------------
// tga_dec_core: byte-at-a-time decode state of the targa pixel stream
// Tracks chunk headers, gathers pixel bytes and forms one result per pixel or run.
// ----------------------------------------------------------------------------
module tga_dec_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  input  logic             start_image_i,
  input  tga_pkg::cfg_t    cfg_i,
  output logic             res_valid_o,
  output tga_pkg::result_t res_o
);
  import tga_pkg::*;

  decode_phase_e        phase_q, phase_d;
  logic [1:0]           bip_q, bip_d;
  logic [23:0]          hold_q, hold_d;
  logic [7:0]           chunk_q, chunk_d;
  logic [PixCountW-1:0] left_q, left_d;

  // view of the state after an optional image start
  decode_phase_e        phase_s;
  logic [1:0]           bip_s;
  logic [23:0]          hold_s;
  logic [7:0]           chunk_s;
  logic [PixCountW-1:0] left_s;

  logic [7:0]           count;
  logic [7:0]           rep;
  logic                 swap;
  logic [7:0]           p0, p2, p3;
  logic                 last_byte;

  // Apply start of image
  always_comb begin
    if (start_image_i) begin
      phase_s = cfg_i.rle ? PH_HEADER : PH_PLAIN;
      bip_s   = 2'd0;
      hold_s  = '0;
      chunk_s = '0;
      left_s  = cfg_i.area;
    end else begin
      phase_s = phase_q;
      bip_s   = bip_q;
      hold_s  = hold_q;
      chunk_s = chunk_q;
      left_s  = left_q;
    end
  end

  // Decode one byte
  always_comb begin
    phase_d     = phase_s;
    bip_d       = bip_s;
    hold_d      = hold_s;
    chunk_d     = chunk_s;
    left_d      = left_s;
    res_valid_o = 1'b0;
    swap        = 1'b0;
    rep         = 8'd1;

    // header count: raw gives low bits + 1, run gives value - 127, same form
    count = {1'b0, data_byte_i[6:0]} + 8'd1;
    if ({{(PixCountW-8){1'b0}}, count} > left_s) begin
      count = left_s[7:0];
    end

    last_byte = cfg_i.is3 ? (bip_s >= 2'd2) : (bip_s >= 2'd3);

    p0 = hold_s[7:0];
    if (cfg_i.is3) begin
      p2 = data_byte_i;
      p3 = 8'd0;
    end else begin
      p2 = hold_s[23:16];
      p3 = data_byte_i;
    end

    if (left_s != '0) begin
      if (phase_s == PH_HEADER) begin
        phase_d = data_byte_i[7] ? PH_RUN : PH_RAW;
        chunk_d = count;
        bip_d   = 2'd0;
      end else if (!last_byte) begin
        unique case (bip_s)
          2'd0:    hold_d[7:0]   = data_byte_i;
          2'd1:    hold_d[15:8]  = data_byte_i;
          2'd2:    hold_d[23:16] = data_byte_i;
          default: hold_d        = hold_s;
        endcase
        bip_d = bip_s + 2'd1;
      end else begin
        bip_d       = 2'd0;
        res_valid_o = accept_i;
        unique case (phase_s)
          PH_PLAIN: begin
            swap = !cfg_i.is3;
            rep  = 8'd1;
          end
          PH_RAW: begin
            swap    = 1'b1;
            rep     = 8'd1;
            chunk_d = chunk_s - 8'd1;
            if (chunk_d == 8'd0) begin
              phase_d = PH_HEADER;
            end
          end
          default: begin
            swap    = 1'b1;
            rep     = chunk_s;
            chunk_d = 8'd0;
            phase_d = PH_HEADER;
          end
        endcase
        if ({{(PixCountW-8){1'b0}}, rep} > left_s) begin
          rep = left_s[7:0];
        end
        left_d = left_s - {{(PixCountW-8){1'b0}}, rep};
      end
    end

    res_o.byte0 = swap ? p2 : p0;
    res_o.byte1 = hold_s[15:8];
    res_o.byte2 = swap ? p0 : p2;
    res_o.byte3 = p3;
    res_o.rep   = rep;
    res_o.last  = (left_d == '0);
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      bip_q   <= 2'd0;
      hold_q  <= '0;
      chunk_q <= '0;
      left_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      bip_q   <= bip_d;
      hold_q  <= hold_d;
      chunk_q <= chunk_d;
      left_q  <= left_d;
    end
  end

endmodule

// ===== src/tga_skid.sv =====
// ----------------------------------------------------------------------------
// tga_skid: two-entry result buffer
// Registers result beats; input keeps flowing under consumer stall until full.
// ----------------------------------------------------------------------------
module tga_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tga_pkg::result_t data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             stall_i,
  output tga_pkg::result_t data_o
);
  import tga_pkg::*;

  result_t    head_q, head_d;
  result_t    tail_q, tail_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = head_q;
  assign pop     = valid_o && !stall_i;

  // Move entries on push and pop
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    unique case (cnt_q)
      2'd0: begin
        if (push_i) begin
          head_d = data_i;
          cnt_d  = 2'd1;
        end
      end
      2'd1: begin
        if (push_i && pop) begin
          head_d = data_i;
        end else if (push_i) begin
          tail_d = data_i;
          cnt_d  = 2'd2;
        end else if (pop) begin
          cnt_d = 2'd0;
        end
      end
      default: begin
        if (pop) begin
          head_d = tail_q;
          cnt_d  = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  // Never write into a full buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("result pushed into full buffer");

  // Fill level stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("buffer count out of range");

  // A pop from a full buffer promotes the tail entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !stall_i) |=> (cnt_q == 2'd1 && head_q == $past(tail_q)))
    else $error("tail entry not promoted");

  // A push into an empty buffer shows that beat next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 && push_i) |=> (valid_o && head_q == $past(data_i)))
    else $error("pushed beat not presented");

endmodule
